[rtl/core/quaternion_to_euler_degrees_defines.svh]
// Assertion macros used by the checker module.
`ifndef QUATERNION_TO_EULER_DEGREES_DEFINES_SVH
`define QUATERNION_TO_EULER_DEGREES_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define Q2E_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/q2e_pkg.sv]
`timescale 1ns / 1ps
package q2e_pkg;
    localparam int QUAT_WIDTH   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int STEPS        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int DEG_W        = 9;
    localparam int OP_W         = 34;   // roll and yaw operands, Q.30
    localparam int S_W          = 32;   // clamped pitch term
    localparam int RAD_W        = 61;   // radicand 2^60 - s^2
    localparam int ROOT_W       = 31;
    localparam int CW           = 38;   // CORDIC x and y
    localparam int ZW           = 34;   // CORDIC angle, 2^31 is a half turn
    localparam logic [DEG_W-1:0] DEG_MAX = 9'd360;

    typedef struct packed {
        logic signed [OP_W-1:0] rn;
        logic signed [OP_W-1:0] rd;
        logic signed [OP_W-1:0] yn;
        logic signed [OP_W-1:0] yd;
        logic signed [S_W-1:0]  s;
    } side_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Offset angle to whole degrees; the pitch path uses the quarter-turn offset.
    function automatic logic [DEG_W-1:0] to_deg(input logic signed [ZW-1:0] z,
                                                 input logic pitch);
        logic signed [ZW:0] off;
        logic [ZW+8:0]      prod;
        logic [ZW+8:0]      d;
        logic [DEG_W-1:0]   r;
        off  = pitch ? ({z[ZW-1], z} + (35'sd1 <<< 30)) : ({z[ZW-1], z} + (35'sd1 <<< 31));
        prod = {9'd0, off[ZW-1:0]} * 43'd360;
        d    = pitch ? (prod >> 31) : (prod >> 32);
        if (off[ZW]) r = '0;
        else if (d > 43'd360) r = DEG_MAX;
        else r = d[DEG_W-1:0];
        return r;
    endfunction
endpackage

[rtl/core/q2e_front.sv]
`timescale 1ns / 1ps
module q2e_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] quat_w,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] quat_x,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] quat_y,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] quat_z,
    output logic                                out_valid,
    output q2e_pkg::side_t                      out_side,
    output logic [q2e_pkg::RAD_W-1:0]           out_rad
);
    localparam int QW   = q2e_pkg::QUAT_WIDTH;
    localparam int SH_R = (QW >= 16) ? QW - 16 : 0;
    localparam int SH_L = (QW < 16) ? 16 - QW : 0;

    function automatic logic signed [15:0] q15(input logic signed [QW-1:0] v);
        logic signed [QW+15:0] t;
        t = {{16{v[QW-1]}}, v};
        if (QW >= 16) t = t >>> SH_R;
        else t = t <<< SH_L;
        return t[15:0];
    endfunction

    logic [3:0] v_reg;
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, xx_reg, yy_reg, zz_reg, wy_reg, zx_reg;
    q2e_pkg::side_t sum_reg, sq_side_reg;
    logic [q2e_pkg::RAD_W-1:0] rad_reg;
    logic signed [33:0] s_full;
    logic signed [63:0] s_sq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_comb begin
        s_full = 34'sd2 * ({{2{wy_reg[31]}}, wy_reg} - {{2{zx_reg[31]}}, zx_reg});
        s_sq   = sum_reg.s * sum_reg.s;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= q15(quat_w);
            x_reg <= q15(quat_x);
            y_reg <= q15(quat_y);
            z_reg <= q15(quat_z);
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
            sum_reg.rn <= 34'sd2 * ({{2{wx_reg[31]}}, wx_reg} + {{2{yz_reg[31]}}, yz_reg});
            sum_reg.rd <= (34'sd1 <<< 30) - 34'sd2 * ({2'b0, xx_reg} + {2'b0, yy_reg});
            sum_reg.yn <= 34'sd2 * ({{2{wz_reg[31]}}, wz_reg} + {{2{xy_reg[31]}}, xy_reg});
            sum_reg.yd <= (34'sd1 <<< 30) - 34'sd2 * ({2'b0, yy_reg} + {2'b0, zz_reg});
            if (s_full > (34'sd1 <<< 30)) sum_reg.s <= 32'sd1 <<< 30;
            else if (s_full < -(34'sd1 <<< 30)) sum_reg.s <= -(32'sd1 <<< 30);
            else sum_reg.s <= s_full[31:0];
            sq_side_reg <= sum_reg;
            rad_reg <= (61'd1 << 60) - s_sq[60:0];
        end
    end

    assign out_valid = v_reg[3];
    assign out_side  = sq_side_reg;
    assign out_rad   = rad_reg;
endmodule

[rtl/core/q2e_sqrt.sv]
`timescale 1ns / 1ps
module q2e_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  q2e_pkg::side_t                in_side,
    input  logic [q2e_pkg::RAD_W-1:0]     in_rad,
    output logic                          out_valid,
    output q2e_pkg::side_t                out_side,
    output logic [q2e_pkg::ROOT_W-1:0]    out_root
);
    localparam int NB = q2e_pkg::ROOT_W;
    localparam int RW = q2e_pkg::RAD_W;

    logic [NB:0]    v_reg;
    logic [RW-1:0]  rem_reg  [0:NB];
    logic [NB-1:0]  root_reg [0:NB];
    q2e_pkg::side_t side_reg [0:NB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NB-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_rad;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // One root bit a stage, most significant first.
    genvar j;
    generate
        for (j = 0; j < NB; j++) begin : g_bit
            localparam int K = NB - 1 - j;
            logic [RW+1:0] trial;
            assign trial = ({{(RW+2-NB){1'b0}}, root_reg[j]} << (K + 1))
                         + ({{(RW+1){1'b0}}, 1'b1} << (2 * K));
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[j+1] <= side_reg[j];
                    if ({2'b0, rem_reg[j]} >= trial) begin
                        rem_reg[j+1]  <= rem_reg[j] - trial[RW-1:0];
                        root_reg[j+1] <= root_reg[j] | (NB'(1) << K);
                    end else begin
                        rem_reg[j+1]  <= rem_reg[j];
                        root_reg[j+1] <= root_reg[j];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NB];
    assign out_side  = side_reg[NB];
    assign out_root  = root_reg[NB];
endmodule

[rtl/core/q2e_cordic.sv]
`timescale 1ns / 1ps
module q2e_cordic (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [q2e_pkg::OP_W-1:0]  in_y,
    input  logic signed [q2e_pkg::OP_W-1:0]  in_x,
    output logic                             out_valid,
    output logic signed [q2e_pkg::ZW-1:0]    out_z
);
    localparam int N  = q2e_pkg::STEPS;
    localparam int CW = q2e_pkg::CW;
    localparam int ZW = q2e_pkg::ZW;
    localparam int OW = q2e_pkg::OP_W;

    logic [N:0]           v_reg;
    logic [N:0]           zero_reg;
    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic signed [CW-1:0] xe, ye;

    assign xe = {{(CW-OW){in_x[OW-1]}}, in_x};
    assign ye = {{(CW-OW){in_y[OW-1]}}, in_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    // Left half plane is folded over by a half turn before the first step.
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (in_x[OW-1]) begin
                x_reg[0] <= -xe;
                y_reg[0] <= -ye;
                z_reg[0] <= in_y[OW-1] ? -(34'sd1 <<< 31) : (34'sd1 <<< 31);
            end else begin
                x_reg[0] <= xe;
                y_reg[0] <= ye;
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            logic signed [CW-1:0] dx, dy;
            logic signed [ZW-1:0] da;
            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;
            assign da = {{(ZW-32){1'b0}}, q2e_pkg::atan_entry(5'(i))};
            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (!y_reg[i][CW-1]) begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + da;
                    end else begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - da;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N];
    assign out_z     = zero_reg[N] ? '0 : z_reg[N];
endmodule

[rtl/core/quaternion_to_euler_degrees.sv]
`timescale 1ns / 1ps
// Quaternion to Euler angles in whole degrees.
// Input channel s_: one quaternion per beat, quat_w/x/y/z in signed Q1.15.
// Output channel m_: roll_deg, yaw_deg (offset by a half turn) and pitch_deg
// (offset by a quarter turn, doubled scale), each 0..360.
// Throughput is one beat per cycle unless m_ready stalls the pipeline.
// From acceptance to m_valid the pipeline runs through four front stages for
// conversion, products, sums and the square of the pitch term, an input
// register and 31 bit stages of the square root, one fold stage and one
// stage per iteration of the CORDIC units, and the output register.
// The whole pipeline advances together: when the receiver holds m_ready low
// with a result waiting, every stage freezes and s_ready drops, so nothing
// is lost or repeated.
// Reset (aresetn low at a clock edge) clears every valid bit; items in
// flight are dropped and m_valid is low afterwards.
module quaternion_to_euler_degrees (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] s_quat_w,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] s_quat_x,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] s_quat_y,
    input  logic signed [q2e_pkg::QUAT_WIDTH-1:0] s_quat_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [q2e_pkg::DEG_W-1:0]             m_roll_deg,
    output logic [q2e_pkg::DEG_W-1:0]             m_pitch_deg,
    output logic [q2e_pkg::DEG_W-1:0]             m_yaw_deg
);
    localparam int OW = q2e_pkg::OP_W;

    logic en;
    logic f_valid, r_valid, c_valid;
    q2e_pkg::side_t f_side, r_side;
    logic [q2e_pkg::RAD_W-1:0]  f_rad;
    logic [q2e_pkg::ROOT_W-1:0] root;
    logic signed [q2e_pkg::ZW-1:0] roll_z, pitch_z, yaw_z;
    logic m_valid_reg;
    logic [q2e_pkg::DEG_W-1:0] roll_reg, pitch_reg, yaw_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    q2e_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .quat_w(s_quat_w), .quat_x(s_quat_x), .quat_y(s_quat_y), .quat_z(s_quat_z),
        .out_valid(f_valid), .out_side(f_side), .out_rad(f_rad)
    );

    q2e_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(f_valid),
        .in_side(f_side), .in_rad(f_rad),
        .out_valid(r_valid), .out_side(r_side), .out_root(root)
    );

    q2e_cordic u_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(r_valid),
        .in_y(r_side.rn), .in_x(r_side.rd), .out_valid(), .out_z(roll_z)
    );

    q2e_cordic u_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(r_valid),
        .in_y({{(OW-q2e_pkg::S_W){r_side.s[q2e_pkg::S_W-1]}}, r_side.s}),
        .in_x({{(OW-q2e_pkg::ROOT_W){1'b0}}, root}),
        .out_valid(c_valid), .out_z(pitch_z)
    );

    q2e_cordic u_yaw (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(r_valid),
        .in_y(r_side.yn), .in_x(r_side.yd), .out_valid(), .out_z(yaw_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg  <= q2e_pkg::to_deg(roll_z, 1'b0);
            pitch_reg <= q2e_pkg::to_deg(pitch_z, 1'b1);
            yaw_reg   <= q2e_pkg::to_deg(yaw_z, 1'b0);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_roll_deg  = roll_reg;
    assign m_pitch_deg = pitch_reg;
    assign m_yaw_deg   = yaw_reg;
endmodule

[rtl/core/q2e_checker.sv]
`timescale 1ns / 1ps
`include "quaternion_to_euler_degrees_defines.svh"
module q2e_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [q2e_pkg::DEG_W-1:0] m_roll_deg,
    input logic [q2e_pkg::DEG_W-1:0] m_pitch_deg,
    input logic [q2e_pkg::DEG_W-1:0] m_yaw_deg
);
    `Q2E_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_roll_deg) && $stable(m_pitch_deg) && $stable(m_yaw_deg), "result beat changed while stalled")
    `Q2E_ASSERT(a_ready, !m_valid || m_ready |-> s_ready, "input refused with room free")
    `Q2E_ASSERT(a_range, m_valid |-> m_roll_deg <= 9'd360 && m_pitch_deg <= 9'd360 && m_yaw_deg <= 9'd360, "angle above 360")
    `Q2E_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid, "result beat after reset")
endmodule

bind quaternion_to_euler_degrees q2e_checker u_q2e_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_roll_deg(m_roll_deg),
    .m_pitch_deg(m_pitch_deg), .m_yaw_deg(m_yaw_deg)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
    localparam int QW = q2e_pkg::QUAT_WIDTH;
    localparam int DW = q2e_pkg::DEG_W;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } quat_t;

    typedef struct packed {
        logic [DW-1:0] roll;
        logic [DW-1:0] pitch;
        logic [DW-1:0] yaw;
    } euler_t;

    localparam longint HALF = 64'sd2147483648;
    localparam longint ONE30 = 64'sd1073741824;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 80;

    // Binary angles of atan(2^-i), with a half turn at 2^31.
    localparam longint ROT_ANGLE [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [QW-1:0] s_quat_w = '0;
    logic signed [QW-1:0] s_quat_x = '0;
    logic signed [QW-1:0] s_quat_y = '0;
    logic signed [QW-1:0] s_quat_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DW-1:0] m_roll_deg;
    logic [DW-1:0] m_pitch_deg;
    logic [DW-1:0] m_yaw_deg;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    quat_t  next_quat;
    int     beats_in = 0;
    int     beats_out = 0;
    int     mismatches = 0;
    int     cycles = 0;

    quaternion_to_euler_degrees i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_deg(m_roll_deg), .m_pitch_deg(m_pitch_deg), .m_yaw_deg(m_yaw_deg)
    );

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            ang = (yv >= 0) ? HALF : -HALF;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < q2e_pkg::STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv += dx;
                yv -= dy;
                ang += ROT_ANGLE[i];
            end else begin
                xv -= dx;
                yv += dy;
                ang -= ROT_ANGLE[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [DW-1:0] whole_degrees(longint off, int span_log2);
        longint d;
        if (off < 0) return '0;
        d = (off * 360) >>> span_log2;
        if (d > 360) d = 360;
        return d[DW-1:0];
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint w, x, y, z, s, c;
        euler_t e;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        s = 2 * (w * y - z * x);
        if (s > ONE30) s = ONE30;
        if (s < -ONE30) s = -ONE30;
        c = longint'(int_sqrt(longint'(ONE30 * ONE30 - s * s)));
        e.roll  = whole_degrees(vector_angle(2 * (w * x + y * z),
                                ONE30 - 2 * (x * x + y * y)) + HALF, 32);
        e.pitch = whole_degrees(vector_angle(s, c) + ONE30, 31);
        e.yaw   = whole_degrees(vector_angle(2 * (w * z + x * y),
                                ONE30 - 2 * (y * y + z * z)) + HALF, 32);
        return e;
    endfunction

    function automatic int sender_idle_pct(int n);
        if (n < 600) return 31;
        if (n < 1200) return 76;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int n);
        if (n < 600) return 76;
        if (n < 1200) return 31;
        return 0;
    endfunction

    function automatic quat_t random_unit_quat();
        real a, b, c, d, len;
        quat_t q;
        do begin
            a = ($itor($urandom_range(65535)) - 32768.0) / 32768.0;
            b = ($itor($urandom_range(65535)) - 32768.0) / 32768.0;
            c = ($itor($urandom_range(65535)) - 32768.0) / 32768.0;
            d = ($itor($urandom_range(65535)) - 32768.0) / 32768.0;
            len = $sqrt(a * a + b * b + c * c + d * d);
        end while (len < 0.01);
        q.w = QW'($rtoi(a / len * 32767.0));
        q.x = QW'($rtoi(b / len * 32767.0));
        q.y = QW'($rtoi(c / len * 32767.0));
        q.z = QW'($rtoi(d / len * 32767.0));
        return q;
    endfunction

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        quat_t q;
        // Zero vector, identity, sign extremes, gimbal lock both ways (pitch term
        // clamped), and single components at their limits.
        pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
        pending_quats.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0});
        pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
        pending_quats.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
        pending_quats.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
        pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd32767, 16'sd0});
        pending_quats.push_back('{16'sd32767, 16'sd0, -16'sd32768, 16'sd0});
        pending_quats.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
        pending_quats.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd0});
        pending_quats.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
        pending_quats.push_back('{16'sd0, 16'sd0, -16'sd32768, 16'sd0});
        pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
        pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd32768});
        pending_quats.push_back('{16'sd0, 16'sd23170, 16'sd23170, 16'sd0});
        pending_quats.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        pending_quats.push_back('{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384});
        pending_quats.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
        pending_quats.push_back('{16'sd0, -16'sd32768, 16'sd0, -16'sd32768});
        // Mostly unit quaternions, the rest any bit pattern at all.
        for (int i = 0; i < 1800; i++) begin
            if ($urandom_range(99) < 65) begin
                q = random_unit_quat();
            end else begin
                q.w = QW'($urandom);
                q.x = QW'($urandom);
                q.y = QW'($urandom);
                q.z = QW'($urandom);
            end
            pending_quats.push_back(q);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_quats.size() != 0 || s_valid || expected_angles.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d quaternions (directed extremes, unit and raw random)",
                 beats_in);
        $display("under sender and receiver stalls; %0d angle triples checked, %0d wrong.",
                 beats_out, mismatches);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding.", expected_angles.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Driver: a beat stays on the bus unchanged until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_quats.size() != 0 && $urandom_range(99) >= sender_idle_pct(beats_in)) begin
                next_quat = pending_quats.pop_front();
                s_quat_w <= next_quat.w;
                s_quat_x <= next_quat.x;
                s_quat_y <= next_quat.y;
                s_quat_z <= next_quat.z;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= receiver_idle_pct(beats_in));
    end

    // Monitor: predicts on every accepted input beat, checks every output beat.
    always @(posedge aclk) begin
        euler_t want;
        if (aresetn && s_valid && s_ready) begin
            expected_angles.push_back(euler_of('{s_quat_w, s_quat_x, s_quat_y, s_quat_z}));
            beats_in++;
        end
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected beat: roll %0d pitch %0d yaw %0d",
                             m_roll_deg, m_pitch_deg, m_yaw_deg);
            end else begin
                want = expected_angles.pop_front();
                if (m_roll_deg !== want.roll || m_pitch_deg !== want.pitch ||
                    m_yaw_deg !== want.yaw) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Beat %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 beats_out, want.roll, want.pitch, want.yaw,
                                 m_roll_deg, m_pitch_deg, m_yaw_deg);
                end
            end
        end
    end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/q2e_pkg.sv
rtl/core/q2e_front.sv
rtl/core/q2e_sqrt.sv
rtl/core/q2e_cordic.sv
rtl/core/quaternion_to_euler_degrees.sv
rtl/core/q2e_checker.sv
tb/sv/tb.sv
